// ===== rtl/core/gcrr_pkg.sv =====
package gcrr_pkg;

    localparam int CHAR_W = 21;
    localparam int WORD_W = 32;
    localparam int SLOT_W = 11;
    localparam int ENT_W  = CHAR_W + 2 * WORD_W;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] tag_char;
        logic [WORD_W-1:0] tag_fore;
        logic [WORD_W-1:0] tag_back;
    } t_entry;

endpackage

// ===== rtl/core/glyph_cache_round_robin_top.sv =====
// path: an accepted beat reads its set row from the tag memory; when SET_COUNT is not a power
//   of two, the ST_ADDR state first reduces the character code to its set
// flow: one item at a time; each item reads its set row from the tag memory, then compares and,
//   on an insert, writes the row back, and the next read waits for that and for i_out_stall
// reset: after i_rst_n releases, a clearing pass writes zero to all SET_COUNT rows,
//   one row per cycle, and input stays stalled until the pass is done
module glyph_cache_round_robin_top #(
    parameter int SET_COUNT = 128,
    parameter int WAYS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [gcrr_pkg::CHAR_W-1:0] i_char_code,
    input  logic [gcrr_pkg::WORD_W-1:0] i_fore_word,
    input  logic [gcrr_pkg::WORD_W-1:0] i_back_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [gcrr_pkg::SLOT_W-1:0] o_slot
);
    import gcrr_pkg::*;

    localparam int SETW    = $clog2(SET_COUNT);
    localparam int WAYW    = $clog2(WAYS);
    localparam int ROW_W   = WAYW + WAYS * ENT_W;
    localparam int ENTRY_W = $clog2(SET_COUNT * WAYS);
    localparam int SUM_W   = (ENTRY_W > SLOT_W) ? ENTRY_W : SLOT_W;
    localparam bit IS_POW2 = ((SET_COUNT & (SET_COUNT - 1)) == 0);

    // set = code mod SET_COUNT through an exact reciprocal for all 21-bit codes
    localparam int DIV_SHIFT = CHAR_W + SETW;
    localparam int RECIP_W   = CHAR_W + 2;
    localparam int PROD_W    = CHAR_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + SET_COUNT - 1) / SET_COUNT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    t_state r_state, n_state;

    logic              r_act;
    logic [CHAR_W-1:0] r_char;
    logic [WORD_W-1:0] r_fore;
    logic [WORD_W-1:0] r_back;
    logic [CHAR_W-1:0] r_quot;
    logic [SETW-1:0]   r_set;
    logic [SUM_W-1:0]  r_base;
    logic [SETW-1:0]   r_clr_cnt;
    logic [ROW_W-1:0]  r_rdata;
    logic [ROW_W-1:0]  r_mem [SET_COUNT];
    logic              r_out_valid;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;

    logic              in_accept;
    logic              finish;
    logic              mem_re;
    logic              mem_we;
    logic              clr_done;
    logic [PROD_W-1:0] prod;
    logic [CHAR_W-1:0] quot_next;
    logic [CHAR_W-1:0] rem;
    logic [SETW-1:0]   set_direct;
    logic [SETW-1:0]   set_div;
    logic [SETW-1:0]   rd_set;
    logic [SETW-1:0]   wr_set;
    logic [ROW_W-1:0]  wr_row;
    logic [ROW_W-1:0]  new_row;
    logic [WAYW-1:0]   ptr;
    logic [WAYW-1:0]   way_ptr;
    logic [WAYW-1:0]   ptr_next;
    logic [WAYS-1:0]   match;
    logic [WAYW-1:0]   match_way;
    logic              found;
    logic              hit_next;
    logic [SUM_W-1:0]  slot_sum;

    assign in_accept = i_in_valid && !o_in_stall;
    assign clr_done  = (r_clr_cnt == SETW'(SET_COUNT - 1));

    assign set_direct = i_char_code[SETW-1:0];
    assign prod       = PROD_W'(i_char_code) * PROD_W'(RECIP);
    assign quot_next  = CHAR_W'(prod >> DIV_SHIFT);
    assign rem        = r_char - CHAR_W'(r_quot * CHAR_W'(SET_COUNT));
    assign set_div    = rem[SETW-1:0];
    assign rd_set     = (r_state == ST_ADDR) ? set_div : set_direct;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) n_state = IS_POW2 ? ST_LOOK : ST_ADDR;
            end
            ST_ADDR: begin
                n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (finish) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        finish     = 1'b0;
        wr_set     = r_set;
        wr_row     = new_row;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                wr_set = r_clr_cnt;
                wr_row = '0;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                mem_re     = in_accept && IS_POW2;
            end
            ST_ADDR: begin
                mem_re = 1'b1;
            end
            ST_LOOK: begin
                finish = !(r_out_valid && i_out_stall);
                mem_we = finish && (r_act == ACT_INSERT);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // compare all ways of the row, lowest matching way wins
    always_comb begin
        t_entry ent;
        ptr       = r_rdata[ROW_W-1 -: WAYW];
        match_way = '0;
        found     = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            ent      = r_rdata[w*ENT_W +: ENT_W];
            match[w] = (ent.tag_char == r_char) && (ent.tag_fore == r_fore)
                       && (ent.tag_back == r_back);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                match_way = WAYW'(w);
                found     = 1'b1;
            end
        end
    end

    always_comb begin
        t_entry ins;
        ins.tag_char = r_char;
        ins.tag_fore = r_fore;
        ins.tag_back = r_back;
        way_ptr  = ({1'b0, ptr} >= (WAYW + 1)'(WAYS)) ? '0 : ptr;
        ptr_next = (way_ptr == WAYW'(WAYS - 1)) ? '0 : way_ptr + 1'b1;
        new_row  = r_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (way_ptr == WAYW'(w)) new_row[w*ENT_W +: ENT_W] = ins;
        end
        new_row[ROW_W-1 -: WAYW] = ptr_next;
        if (r_act == ACT_INSERT) begin
            hit_next = 1'b1;
            slot_sum = r_base + SUM_W'(way_ptr);
        end else begin
            hit_next = found;
            slot_sum = found ? (r_base + SUM_W'(match_way)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= finish || (r_out_valid && i_out_stall);
            if (r_state == ST_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_act  <= i_action;
            r_char <= i_char_code;
            r_fore <= i_fore_word;
            r_back <= i_back_word;
            r_quot <= quot_next;
        end
        if (mem_re) begin
            r_set  <= rd_set;
            r_base <= SUM_W'(rd_set) * SUM_W'(WAYS);
        end
        if (finish) begin
            r_hit  <= hit_next;
            r_slot <= slot_sum[SLOT_W-1:0];
        end
    end

    // tag memory: one row per set, round-robin pointer in the top bits
    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= r_mem[rd_set];
        if (mem_we) r_mem[wr_set] <= wr_row;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_slot      = r_slot;

endmodule

// ===== rtl/core/gcrr_checker.sv =====
module gcrr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_hit,
    input logic [gcrr_pkg::SLOT_W-1:0] o_slot
);
    import gcrr_pkg::*;

    // reset leaves nothing to deliver and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open right after reset");

    // one item in flight: an accepted beat closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    // a miss always reports slot zero
    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_slot == '0)
        else $error("miss with nonzero slot");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit) && $stable(o_slot))
        else $error("stalled result beat changed");

endmodule

bind glyph_cache_round_robin_top gcrr_checker u_gcrr_checker (.*);

// ===== dv/glyph_cache_round_robin_top_tb.sv =====
`timescale 1ns / 1ps

module glyph_cache_round_robin_top_tb;

    import gcrr_pkg::*;

    localparam int SET_COUNT  = 128;
    localparam int WAYS       = 16;
    localparam int RAND_ITEMS = 1400;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_code;
        logic [WORD_W-1:0] fore_word;
        logic [WORD_W-1:0] back_word;
    } t_glyph_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_glyph_res;

    class t_glyph_scoreboard;
        int unsigned next_way [SET_COUNT];
        t_entry      tags [SET_COUNT*WAYS];
        t_glyph_res  pending [$];
        int          errors;

        function new();
            foreach (next_way[s]) next_way[s] = 0;
            foreach (tags[e]) tags[e] = '0;
            errors = 0;
        endfunction

        // predict the result of one accepted request and update the tag copy
        function void note_input(t_glyph_req req);
            int unsigned set_idx;
            int unsigned base;
            int unsigned way;
            t_glyph_res  res;
            set_idx = req.char_code % SET_COUNT;
            base    = set_idx * WAYS;
            res     = '0;
            if (req.action == ACT_INSERT) begin
                way = next_way[set_idx];
                tags[base+way] = '{tag_char: req.char_code, tag_fore: req.fore_word,
                                   tag_back: req.back_word};
                next_way[set_idx] = (way + 1 == WAYS) ? 0 : way + 1;
                res.hit  = 1'b1;
                res.slot = SLOT_W'(base + way);
            end else begin
                // scan downward so the lowest matching way wins
                for (int w = WAYS - 1; w >= 0; w--) begin
                    if (tags[base+w].tag_char == req.char_code &&
                        tags[base+w].tag_fore == req.fore_word &&
                        tags[base+w].tag_back == req.back_word) begin
                        res.hit  = 1'b1;
                        res.slot = SLOT_W'(base + w);
                    end
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic hit, logic [SLOT_W-1:0] slot);
            t_glyph_res exp_res;
            if (pending.size() == 0) begin
                $error("result beat with nothing pending: hit=%0d slot=%0d", hit, slot);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (hit !== exp_res.hit) begin
                $error("hit mismatch: expected %0d, actual %0d", exp_res.hit, hit);
                errors++;
            end
            if (slot !== exp_res.slot) begin
                $error("slot mismatch: expected %0d, actual %0d", exp_res.slot, slot);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_action;
    logic [CHAR_W-1:0] i_char_code;
    logic [WORD_W-1:0] i_fore_word;
    logic [WORD_W-1:0] i_back_word;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_hit;
    logic [SLOT_W-1:0] o_slot;

    t_glyph_scoreboard sb;
    t_glyph_req        key_pool [$];
    bit                calm = 1'b0;
    int                hot_sets [4] = '{5, 42, 99, SET_COUNT - 1};

    glyph_cache_round_robin_top #(
        .SET_COUNT (SET_COUNT),
        .WAYS      (WAYS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .i_fore_word (i_fore_word),
        .i_back_word (i_back_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_slot      (o_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic offer_request(input t_glyph_req req);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= req.action;
        i_char_code <= req.char_code;
        i_fore_word <= req.fore_word;
        i_back_word <= req.back_word;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(req);
    endtask

    // mostly keys that were inserted before, so lookups reach real hits and evictions
    function automatic t_glyph_req make_random_request();
        t_glyph_req req;
        int         pick;
        pick = $urandom_range(0, 99);
        req.fore_word = $urandom;
        req.back_word = $urandom;
        if ($urandom_range(0, 1) == 0)
            req.char_code = CHAR_W'($urandom_range(0, (1 << CHAR_W) / SET_COUNT - 1)
                                    * SET_COUNT + hot_sets[$urandom_range(0, 3)]);
        else
            req.char_code = CHAR_W'($urandom);
        if (pick < 40) begin
            req.action = ACT_INSERT;
            // duplicate insert of a known key
            if (pick < 8 && key_pool.size() > 0) begin
                req = key_pool[$urandom_range(0, key_pool.size() - 1)];
                req.action = ACT_INSERT;
            end
            key_pool.push_back(req);
            if (key_pool.size() > 48) void'(key_pool.pop_front());
        end else begin
            req.action = ACT_LOOKUP;
            if (pick < 85 && key_pool.size() > 0) begin
                req = key_pool[$urandom_range(0, key_pool.size() - 1)];
                req.action = ACT_LOOKUP;
                // near miss: one bit off in one field
                if (pick >= 75) begin
                    case ($urandom_range(0, 2))
                        0: req.char_code[$urandom_range(0, CHAR_W - 1)] ^= 1'b1;
                        1: req.fore_word[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
                        default: req.back_word[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
                    endcase
                end
            end
        end
        return req;
    endfunction

    // result side
    initial begin
        int unsigned wait_cycles;
        int unsigned beats_seen;
        bit          held;
        beats_seen = 0;
        held       = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held && beats_seen == 500) begin
                // long hold-off so the block backs up into its input
                held        = 1'b1;
                wait_cycles = 300;
            end else begin
                wait_cycles = calm ? 0 : $urandom_range(0, 11);
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_result(o_hit, o_slot);
            beats_seen++;
        end
    end

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_LOOKUP;
        i_char_code <= '0;
        i_fore_word <= '0;
        i_back_word <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cleared store: all-zero key hits slot 0, anything else misses
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h000000, 32'h00000000, 32'h00000000});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h000000, 32'hFFFFFFFF, 32'hFFFFFFFF});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h1FFFFF, 32'h00000000, 32'h00000000});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h000080, 32'h00000000, 32'h00000000});
        // code point above the unicode range, all ones
        offer_request(t_glyph_req'{ACT_INSERT, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE});
        // same key inserted twice: lookup reports the lower way
        offer_request(t_glyph_req'{ACT_INSERT, 21'h10FFFF, 32'h12345678, 32'h9ABCDEF0});
        offer_request(t_glyph_req'{ACT_INSERT, 21'h10FFFF, 32'h12345678, 32'h9ABCDEF0});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h10FFFF, 32'h12345678, 32'h9ABCDEF0});
        offer_request(t_glyph_req'{ACT_INSERT, 21'h000000, 32'h00000000, 32'h00000000});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h000000, 32'h00000000, 32'h00000000});
        offer_request(t_glyph_req'{ACT_INSERT, 21'h000080, 32'hA5A5A5A5, 32'h5A5A5A5A});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h000080, 32'hA5A5A5A5, 32'h5A5A5A5A});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h000080, 32'hA5A5A5A5, 32'h00000000});
        offer_request(t_glyph_req'{ACT_INSERT, 21'h155555, 32'hAAAAAAAA, 32'h55555555});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h155555, 32'hAAAAAAAA, 32'h55555555});
        offer_request(t_glyph_req'{ACT_INSERT, 21'h0AAAAA, 32'h55555555, 32'hAAAAAAAA});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h0AAAAA, 32'h55555555, 32'hAAAAAAAA});
        offer_request(t_glyph_req'{ACT_LOOKUP, 21'h0AAAAA, 32'h55555555, 32'hAAAAAAAB});

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            offer_request(make_random_request());
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        for (int w = 0; w < 20000 && sb.pending.size() != 0; w++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gcrr_pkg.sv
rtl/core/glyph_cache_round_robin_top.sv
rtl/core/gcrr_checker.sv
dv/glyph_cache_round_robin_top_tb.sv
